FILE: sv/dtp_pkg.sv
package dtp_pkg;

  // width of the shared serial multiplier operands
  localparam int MulW = 34;

  localparam logic [63:0] Q30One    = 64'd1073741824;
  localparam logic [63:0] PiHalfQ30 = 64'd1686629713;
  localparam logic signed [31:0] Sentinel = 32'sd655353446;
  localparam logic [15:0] ZeroBand = 16'd246;
  localparam logic [15:0] StallEps = 16'd3277;
  localparam logic [63:0] TolReset = 64'h0CCD_0100_0100_0080;

  // finish causes
  localparam logic [1:0] CauseRun     = 2'd0;
  localparam logic [1:0] CauseReached = 2'd1;
  localparam logic [1:0] CauseStalled = 2'd2;

  // register indexes
  localparam logic [2:0] CfgTargetXy   = 3'd0;
  localparam logic [2:0] CfgTargetHdg  = 3'd1;
  localparam logic [2:0] CfgGainX      = 3'd2;
  localparam logic [2:0] CfgGainY      = 3'd3;
  localparam logic [2:0] CfgGainTurn   = 3'd4;
  localparam logic [2:0] CfgSpeedLim   = 3'd5;
  localparam logic [2:0] CfgTurnSet    = 3'd6;
  localparam logic [2:0] CfgTolerances = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE, ST_STALL, ST_SIN, ST_COS, ST_CAPC,
    ST_MCRX, ST_MSRY, ST_MCRY, ST_MSRX, ST_MEXX, ST_MEYY,
    ST_TGT, ST_MGX, ST_MGY, ST_SHAPE, ST_SLEW, ST_MTURN, ST_TURN, ST_EMIT
  } dtp_state_e;

  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // quarter-wave sine by odd taylor terms, q30 in and out
  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] x, x2, t;
    x  = (u * PiHalfQ30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30One;
    t  = Q30One - ((x2 * t) >> 30) / 110;
    t  = Q30One - ((x2 * t) >> 30) / 72;
    t  = Q30One - ((x2 * t) >> 30) / 42;
    t  = Q30One - ((x2 * t) >> 30) / 20;
    t  = Q30One - ((x2 * t) >> 30) / 6;
    t  = (x * t) >> 30;
    return (t > Q30One) ? Q30One : t;
  endfunction

  // one table entry from a 32-bit phase
  function automatic logic signed [16:0] sine_val(input logic [63:0] ph);
    logic [1:0]  q;
    logic [63:0] f, m, r;
    q = ph[31:30];
    f = ph & (Q30One - 64'd1);
    m = quarter_sine(q[0] ? (Q30One - f) : f);
    r = (m + 64'd16384) >> 15;
    return q[1] ? -$signed(r[16:0]) : $signed(r[16:0]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [48:0] v);
    if (v > 49'sd32767) return 16'sh7FFF;
    if (v < -49'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    logic signed [32:0] w;
    w = 33'(v);
    return (w < 0) ? 33'(-w) : 33'(w);
  endfunction

  // clamp to +/- max speed
  function automatic logic signed [48:0] clamp_mx(input logic signed [48:0] s,
                                                  input logic [15:0] mx);
    logic signed [48:0] mxs;
    mxs = $signed({33'd0, mx});
    if (s > mxs) return mxs;
    if (s < -mxs) return -mxs;
    return s;
  endfunction

  // zero band, then minimum magnitude
  function automatic logic signed [48:0] shape_min(input logic signed [48:0] s,
                                                   input logic [15:0] mn);
    logic [48:0] m;
    logic signed [48:0] mns;
    m   = (s < 0) ? 49'(-s) : 49'(s);
    mns = $signed({33'd0, mn});
    if (m < {33'd0, ZeroBand}) return '0;
    if (m < {33'd0, mn}) return (s > 0) ? mns : -mns;
    return s;
  endfunction

  function automatic logic signed [15:0] slew(input logic signed [17:0] s,
                                              input logic signed [15:0] last,
                                              input logic [15:0] lim);
    logic signed [18:0] adj, lims, r;
    adj  = 19'(s) - 19'(last);
    lims = $signed({3'd0, lim});
    r    = 19'(s);
    if (adj > lims) r = 19'(last) + lims;
    if (adj < -lims) r = 19'(last) - lims;
    return sat16(49'(r));
  endfunction

endpackage

FILE: sv/dtp_if.sv
interface dtp_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [15:0] track_angle;
  logic signed [31:0] gyro_heading;

  modport source (output valid, action, pos_x, pos_y, track_angle, gyro_heading,
                  input ready);
  modport sink   (input valid, action, pos_x, pos_y, track_angle, gyro_heading,
                  output ready);
endinterface

interface dtp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_x;
  logic signed [15:0] speed_y;
  logic signed [15:0] speed_turn;
  logic        [1:0]  finish_cause;

  modport source (output valid, speed_x, speed_y, speed_turn, finish_cause,
                  input ready);
  modport sink   (input valid, speed_x, speed_y, speed_turn, finish_cause,
                  output ready);
endinterface

FILE: sv/dtp_serial_mult.sv
module dtp_serial_mult
  import dtp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mul_ctrl_t                 ctrl_i,
  input  logic signed [MulW-1:0]    a_i,
  input  logic signed [MulW-1:0]    b_i,
  output mul_stat_t                 stat_o,
  output logic        [2*MulW-1:0]  prod_o
);

  localparam int CntW = $clog2(MulW);
  localparam logic [CntW-1:0] LastCnt = CntW'(MulW - 1);

  logic signed [MulW-1:0] a_q;
  logic signed [MulW:0]   hi_q, hi_d, sum;
  logic        [MulW-1:0] lo_q, lo_d;
  logic [CntW-1:0]        cnt_q;
  logic                   run_q, done_q;
  logic signed [MulW:0]   addend;

  // one multiplier bit per cycle, top bit carries negative weight
  always_comb begin
    if (!lo_q[0]) begin
      addend = '0;
    end else if (cnt_q == LastCnt) begin
      addend = -(($bits(addend))'(a_q));
    end else begin
      addend = ($bits(addend))'(a_q);
    end
    sum  = hi_q + addend;
    hi_d = {sum[MulW], sum[MulW:1]};
    lo_d = {sum[0], lo_q[MulW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial product registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (run_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod_o      = {hi_q[MulW-1:0], lo_q};
  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !run_q) else $error("multiplier started while busy");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && cnt_q == LastCnt && !ctrl_i.start) |=> done_q)
    else $error("missing done after last step");
  a_done_not_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("done while running");

endmodule

FILE: sv/dtp_sine_rom.sv
module dtp_sine_rom
  import dtp_pkg::*;
#(
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  output logic signed [16:0]       data_o
);

  logic signed [16:0] tab [Depth];

  // constant table worked out at elaboration
  for (genvar k = 0; k < Depth; k++) begin : g_tab
    localparam logic [63:0] Ph = (64'(k) << 32) / Depth;
    assign tab[k] = sine_val(Ph);
  end

  // registered read
  always_ff @(posedge clk_i) begin
    data_o <= tab[addr_i];
  end

endmodule

FILE: sv/drive_to_point_pd_controller_core.sv
// channel   dir  handshake        payload
// in_ch     in   valid / ready    action, pos_x, pos_y, track_angle, gyro_heading
// out_ch    out  valid / ready    speed_x, speed_y, speed_turn, finish_cause
// cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// sample work is paced by the one bit-serial 34x34 multiplier, shared by up to
// nine products (rotation, squared distance, two axis gains, turn gain); a start
// uses two of them (squared distance) and an idle sample none.
// reset is asynchronous, active low; it clears config, history and move state.
// a finished result waits in the output register; the next item is taken
// while it waits, and the sequencer holds at its last step only if the
// register is still full.
module drive_to_point_pd_controller_core
  import dtp_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  dtp_in_if.sink      in_ch,
  dtp_out_if.source   out_ch
);

  localparam int IdxW = $clog2(SINE_TABLE_DEPTH);
  localparam logic [IdxW:0] QuarterIdx = (IdxW+1)'(SINE_TABLE_DEPTH / 4);
  localparam logic [IdxW:0] DepthIdx   = (IdxW+1)'(SINE_TABLE_DEPTH);

  // configuration registers
  logic [63:0]        target_xy_q, speed_lim_q, tol_q;
  logic signed [31:0] target_hdg_q, gain_x_q, gain_y_q, gain_turn_q;
  logic [16:0]        turn_set_q;

  // move state
  logic signed [31:0] hist_x_q [4];
  logic signed [31:0] hist_y_q [4];
  logic signed [31:0] ssum_x_q, ssum_y_q, he_q;
  logic signed [15:0] lspd_x_q, lspd_y_q;
  logic [63:0]        init_dsq_q, last_dsq_q, dsq_q;
  logic               active_q;
  logic [1:0]         last_cause_q;

  // per-item work registers
  logic               action_q;
  logic signed [32:0] rx_q, ry_q;
  logic signed [31:0] hn_q, ex_q, ey_q;
  logic [15:0]        angle_q;
  logic signed [16:0] s_q, c_q;
  logic signed [49:0] pa_q;
  logic signed [48:0] vx_q, vy_q, traw_q;
  logic signed [17:0] shx_q, shy_q;
  logic signed [15:0] r_sx_q, r_sy_q, r_st_q;
  logic [1:0]         r_cause_q;
  logic               launched_q;
  logic               out_valid_q;
  logic signed [15:0] o_sx_q, o_sy_q, o_st_q;
  logic [1:0]         o_cause_q;

  dtp_state_e state_q, state_d;

  mul_ctrl_t                 mul_ctrl;
  mul_stat_t                 mul_stat;
  logic signed [MulW-1:0]    mul_a, mul_b;
  logic        [2*MulW-1:0]  mul_prod;
  logic signed [2*MulW-1:0]  prod_s;

  logic [IdxW-1:0]    rom_addr, sin_idx, cos_idx;
  logic signed [16:0] rom_data;
  logic [IdxW+15:0]   idx_prod;
  logic [IdxW:0]      cos_sum;

  logic               in_xfer, out_xfer, emit_go, is_mul;
  logic signed [32:0] rx_in, ry_in;
  logic signed [31:0] hn_in;
  logic               stall_hit, reach_hit;
  logic [25:0]        tol_h3;
  logic signed [50:0] rot_diff, rot_sum;
  logic signed [32:0] dx, dy;
  logic signed [40:0] kdx, kdy;
  logic signed [67:0] pds_x, pds_y;
  logic signed [15:0] slew_x, slew_y;

  dtp_serial_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .prod_o (mul_prod)
  );

  dtp_sine_rom #(.Depth(SINE_TABLE_DEPTH)) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign prod_s   = $signed(mul_prod);
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_q && out_ch.ready;
  assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || out_ch.ready);

  // field-frame error and heading error of the incoming item
  assign rx_in = 33'($signed(target_xy_q[63:32])) - 33'(in_ch.pos_x);
  assign ry_in = 33'($signed(target_xy_q[31:0])) - 33'(in_ch.pos_y);
  assign hn_in = sat32(64'(target_hdg_q) - 64'(in_ch.gyro_heading));

  // sine and cosine table indexes
  assign idx_prod = (IdxW+16)'(angle_q) * (IdxW+16)'(SINE_TABLE_DEPTH);
  assign sin_idx  = idx_prod[IdxW+15:16];
  assign cos_sum  = {1'b0, sin_idx} + QuarterIdx;
  assign cos_idx  = (cos_sum >= DepthIdx) ? IdxW'(cos_sum - DepthIdx) : cos_sum[IdxW-1:0];

  // stall and target tests
  assign tol_h3    = ({2'd0, tol_q[47:32], 8'd0} << 1) + {2'd0, tol_q[47:32], 8'd0};
  assign stall_hit = (mag33(ssum_x_q) <= {17'd0, StallEps}) &&
                     (mag33(ssum_y_q) <= {17'd0, StallEps}) &&
                     (last_dsq_q <= (init_dsq_q >> 2)) &&
                     (mag33(he_q) <= {7'd0, tol_h3});
  assign reach_hit = (mag33(ey_q) < {9'd0, tol_q[15:0], 8'd0}) &&
                     (mag33(ex_q) < {9'd0, tol_q[31:16], 8'd0}) &&
                     (mag33(he_q) < {9'd0, tol_q[47:32], 8'd0});

  // rotation combine and pd sums
  assign rot_diff = 51'(pa_q) - 51'($signed(mul_prod[49:0]));
  assign rot_sum  = 51'(pa_q) + 51'($signed(mul_prod[49:0]));
  assign dx       = 33'(hist_x_q[0]) - 33'(ex_q);
  assign dy       = 33'(hist_y_q[0]) - 33'(ey_q);
  assign kdx      = (41'(dx) <<< 6) + (41'(dx) <<< 1);
  assign kdy      = (41'(dy) <<< 6) + (41'(dy) <<< 1);
  assign pds_x    = prod_s - 68'(kdx);
  assign pds_y    = prod_s - 68'(kdy);
  assign slew_x   = slew(shx_q, lspd_x_q, tol_q[63:48]);
  assign slew_y   = slew(shy_q, lspd_y_q, tol_q[63:48]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_xfer) state_d = in_ch.action ? ST_STALL : ST_MEXX;
      ST_STALL: begin
        if (!active_q || stall_hit) state_d = ST_EMIT;
        else state_d = ST_SIN;
      end
      ST_SIN:   state_d = ST_COS;
      ST_COS:   state_d = ST_CAPC;
      ST_CAPC:  state_d = ST_MCRX;
      ST_MCRX:  if (mul_stat.done) state_d = ST_MSRY;
      ST_MSRY:  if (mul_stat.done) state_d = ST_MCRY;
      ST_MCRY:  if (mul_stat.done) state_d = ST_MSRX;
      ST_MSRX:  if (mul_stat.done) state_d = ST_MEXX;
      ST_MEXX:  if (mul_stat.done) state_d = ST_MEYY;
      ST_MEYY:  if (mul_stat.done) state_d = action_q ? ST_TGT : ST_EMIT;
      ST_TGT:   state_d = reach_hit ? ST_EMIT : ST_MGX;
      ST_MGX:   if (mul_stat.done) state_d = ST_MGY;
      ST_MGY:   if (mul_stat.done) state_d = ST_SHAPE;
      ST_SHAPE: state_d = ST_SLEW;
      ST_SLEW:  state_d = turn_set_q[16] ? ST_MTURN : ST_EMIT;
      ST_MTURN: if (mul_stat.done) state_d = ST_TURN;
      ST_TURN:  state_d = ST_EMIT;
      ST_EMIT:  if (emit_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, rom address, multiplier operands
  always_comb begin
    in_ch.ready    = (state_q == ST_IDLE);
    rom_addr       = (state_q == ST_SIN) ? sin_idx : cos_idx;
    is_mul         = 1'b1;
    mul_a          = '0;
    mul_b          = '0;
    unique case (state_q)
      ST_MCRX:  begin mul_a = MulW'(c_q);  mul_b = MulW'(rx_q);        end
      ST_MSRY:  begin mul_a = MulW'(s_q);  mul_b = MulW'(ry_q);        end
      ST_MCRY:  begin mul_a = MulW'(c_q);  mul_b = MulW'(ry_q);        end
      ST_MSRX:  begin mul_a = MulW'(s_q);  mul_b = MulW'(rx_q);        end
      ST_MEXX:  begin mul_a = MulW'(ex_q); mul_b = MulW'(ex_q);        end
      ST_MEYY:  begin mul_a = MulW'(ey_q); mul_b = MulW'(ey_q);        end
      ST_MGX:   begin mul_a = MulW'(ex_q); mul_b = MulW'(gain_x_q);    end
      ST_MGY:   begin mul_a = MulW'(ey_q); mul_b = MulW'(gain_y_q);    end
      ST_MTURN: begin mul_a = MulW'(hn_q); mul_b = MulW'(gain_turn_q); end
      default:  is_mul = 1'b0;
    endcase
    mul_ctrl.start = is_mul && !launched_q && !mul_stat.busy;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_ctrl.start) launched_q <= 1'b1;
      else if (mul_stat.done) launched_q <= 1'b0;
      if (emit_go) out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;
    end
  end

  // configuration and move state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_xy_q  <= '0;
      target_hdg_q <= '0;
      gain_x_q     <= '0;
      gain_y_q     <= '0;
      gain_turn_q  <= '0;
      speed_lim_q  <= '0;
      turn_set_q   <= '0;
      tol_q        <= TolReset;
      for (int i = 0; i < 4; i++) begin
        hist_x_q[i] <= (i == 0) ? 32'sd0 : Sentinel;
        hist_y_q[i] <= (i == 0) ? 32'sd0 : Sentinel;
      end
      ssum_x_q     <= Sentinel;
      ssum_y_q     <= Sentinel;
      lspd_x_q     <= '0;
      lspd_y_q     <= '0;
      he_q         <= '0;
      init_dsq_q   <= '0;
      last_dsq_q   <= '0;
      active_q     <= 1'b0;
      last_cause_q <= CauseRun;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTargetXy:   target_xy_q  <= cfg_data_i;
          CfgTargetHdg:  target_hdg_q <= $signed(cfg_data_i[31:0]);
          CfgGainX:      gain_x_q     <= $signed(cfg_data_i[31:0]);
          CfgGainY:      gain_y_q     <= $signed(cfg_data_i[31:0]);
          CfgGainTurn:   gain_turn_q  <= $signed(cfg_data_i[31:0]);
          CfgSpeedLim:   speed_lim_q  <= cfg_data_i;
          CfgTurnSet:    turn_set_q   <= cfg_data_i[16:0];
          CfgTolerances: tol_q        <= cfg_data_i;
          default:       ;
        endcase
      end
      // stall finish
      if (state_q == ST_STALL && active_q && stall_hit) begin
        active_q     <= 1'b0;
        last_cause_q <= CauseStalled;
      end
      // start seeds the move, sample records its distance
      if (state_q == ST_MEYY && mul_stat.done) begin
        if (!action_q) begin
          for (int i = 0; i < 4; i++) begin
            hist_x_q[i] <= (i == 0) ? 32'sd0 : Sentinel;
            hist_y_q[i] <= (i == 0) ? 32'sd0 : Sentinel;
          end
          ssum_x_q     <= Sentinel;
          ssum_y_q     <= Sentinel;
          lspd_x_q     <= '0;
          lspd_y_q     <= '0;
          he_q         <= hn_q;
          init_dsq_q   <= dsq_q + mul_prod[63:0];
          active_q     <= 1'b1;
          last_cause_q <= CauseRun;
        end
        last_dsq_q <= dsq_q + mul_prod[63:0];
      end
      // target finish
      if (state_q == ST_TGT && reach_hit) begin
        active_q     <= 1'b0;
        last_cause_q <= CauseReached;
      end
      // error history and stall sums
      if (state_q == ST_SHAPE) begin
        hist_x_q[0] <= ex_q;
        hist_y_q[0] <= ey_q;
        for (int i = 1; i < 4; i++) begin
          hist_x_q[i] <= hist_x_q[i-1];
          hist_y_q[i] <= hist_y_q[i-1];
        end
        ssum_x_q <= sat32(64'(hist_x_q[2]) - 64'(ex_q));
        ssum_y_q <= sat32(64'(hist_y_q[2]) - 64'(ey_q));
      end
      if (state_q == ST_SLEW) begin
        lspd_x_q <= slew_x;
        lspd_y_q <= slew_y;
      end
      if (state_q == ST_MTURN && mul_stat.done) he_q <= hn_q;
    end
  end

  // datapath work registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q  <= in_ch.action;
      rx_q      <= rx_in;
      ry_q      <= ry_in;
      hn_q      <= hn_in;
      angle_q   <= in_ch.track_angle;
      ex_q      <= sat32(64'(rx_in));
      ey_q      <= sat32(64'(ry_in));
      r_sx_q    <= '0;
      r_sy_q    <= '0;
      r_st_q    <= '0;
      r_cause_q <= CauseRun;
    end
    if (state_q == ST_STALL) begin
      if (!active_q) r_cause_q <= last_cause_q;
      else if (stall_hit) r_cause_q <= CauseStalled;
    end
    if (state_q == ST_COS) s_q <= rom_data;
    if (state_q == ST_CAPC) c_q <= rom_data;
    if (mul_stat.done) begin
      unique case (state_q)
        ST_MCRX, ST_MCRY: pa_q <= $signed(mul_prod[49:0]);
        ST_MSRY:  ex_q  <= sat32(64'(rot_diff >>> 15));
        ST_MSRX:  ey_q  <= sat32(64'(rot_sum >>> 15));
        ST_MEXX:  dsq_q <= mul_prod[63:0];
        ST_MGX:   vx_q  <= pds_x[65:17];
        ST_MGY:   vy_q  <= pds_y[65:17];
        ST_MTURN: traw_q <= prod_s[65:17];
        default:  ;
      endcase
    end
    if (state_q == ST_TGT && reach_hit) r_cause_q <= CauseReached;
    if (state_q == ST_SHAPE) begin
      shx_q <= 18'(shape_min(clamp_mx(vx_q, speed_lim_q[63:48]), speed_lim_q[31:16]));
      shy_q <= 18'(shape_min(clamp_mx(vy_q, speed_lim_q[47:32]), speed_lim_q[15:0]));
    end
    if (state_q == ST_SLEW) begin
      r_sx_q <= slew_x;
      r_sy_q <= slew_y;
    end
    if (state_q == ST_TURN) r_st_q <= sat16(shape_min(traw_q, turn_set_q[15:0]));
    // output register
    if (emit_go) begin
      o_sx_q    <= r_sx_q;
      o_sy_q    <= r_sy_q;
      o_st_q    <= r_st_q;
      o_cause_q <= r_cause_q;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.speed_x      = o_sx_q;
  assign out_ch.speed_y      = o_sy_q;
  assign out_ch.speed_turn   = o_st_q;
  assign out_ch.finish_cause = o_cause_q;

  a_done_in_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> is_mul) else $error("product arrived outside a multiply step");
  a_finish_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> (last_cause_q == CauseReached || last_cause_q == CauseStalled))
    else $error("move ended without a finish cause");
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not loaded into output register");

endmodule

FILE: sim/drive_to_point_pd_controller_core_tb.sv
`default_nettype none

module drive_to_point_pd_controller_core_tb;
  import dtp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SineDepth = 256;
  localparam int StallLimit = 20000;
  localparam int DrainCycles = 400;
  localparam longint MaxMag = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic ActStart = 1'b0;
  localparam logic ActSample = 1'b1;

  typedef struct {
    logic               action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] angle;
    logic signed [31:0] gyro;
  } pose_item_t;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] st;
    logic        [1:0]  cause;
  } drive_cmd_t;

  // predicts drive commands and checks the block's output against them
  class drive_cmd_board;
    longint     sine_q[SineDepth];
    bit [63:0]  tgt_xy, lims, tols;
    longint     tgt_hdg, kx, ky, kt;
    bit [16:0]  turn_cfg;
    longint     hist_x[4], hist_y[4];
    longint     sum_x, sum_y, last_x, last_y, hdg_err;
    bit [63:0]  init_dsq, last_dsq;
    bit         active;
    bit [1:0]   last_cause;
    drive_cmd_t expected_cmds[$];
    int         errors;

    function new();
      bit [63:0] ph, q, f, u, x, x2, t, r;
      longint divs[5];
      divs = '{110, 72, 42, 20, 6};
      // sine table from odd taylor terms
      for (int k = 0; k < SineDepth; k++) begin
        ph = (64'(k) << 32) / SineDepth;
        q  = (ph >> 30) & 3;
        f  = ph & (Q30One - 1);
        u  = q[0] ? Q30One - f : f;
        x  = (u * PiHalfQ30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30One;
        for (int i = 0; i < 5; i++) t = Q30One - ((x2 * t) >> 30) / divs[i];
        t = (x * t) >> 30;
        if (t > Q30One) t = Q30One;
        r = (t + 16384) >> 15;
        sine_q[k] = (q >= 2) ? -longint'(r) : longint'(r);
      end
      tgt_xy = 0; lims = 0; tols = TolReset;
      tgt_hdg = 0; kx = 0; ky = 0; kt = 0; turn_cfg = 0;
      seed();
      hdg_err = 0; init_dsq = 0; last_dsq = 0; active = 0; last_cause = CauseRun;
      errors = 0;
    endfunction

    function void seed();
      hist_x[0] = 0; hist_y[0] = 0;
      for (int i = 1; i < 4; i++) begin
        hist_x[i] = Sentinel; hist_y[i] = Sentinel;
      end
      sum_x = Sentinel; sum_y = Sentinel; last_x = 0; last_y = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint clip32(longint v);
      return clip(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint sext32(bit [31:0] v);
      return longint'($signed(v));
    endfunction

    // max clamp, zero band, then minimum speed
    function longint shape(longint s, longint mx, longint mn);
      if (s > mx) s = mx;
      if (s < -mx) s = -mx;
      if (mag(s) < longint'(ZeroBand)) return 0;
      if (mag(s) < mn) return s > 0 ? mn : -mn;
      return s;
    endfunction

    function longint slew(longint s, longint last, longint lim);
      if (s - last > lim) s = last + lim;
      if (s - last < -lim) s = last - lim;
      return clip(s, -32768, 32767);
    endfunction

    function longint pd_step(longint e, longint gain, inout longint h[4], inout longint s);
      longint d;
      d = h[0] - e;
      h[3] = h[2]; h[2] = h[1]; h[1] = h[0]; h[0] = e;
      s = clip32(h[3] - h[0]);
      return (e * gain + d * (-66)) >>> 17;
    endfunction

    function void write_reg(logic [2:0] idx, bit [63:0] v);
      case (idx)
        CfgTargetXy:   tgt_xy = v;
        CfgTargetHdg:  tgt_hdg = sext32(v[31:0]);
        CfgGainX:      kx = sext32(v[31:0]);
        CfgGainY:      ky = sext32(v[31:0]);
        CfgGainTurn:   kt = sext32(v[31:0]);
        CfgSpeedLim:   lims = v;
        CfgTurnSet:    turn_cfg = v[16:0];
        CfgTolerances: tols = v;
        default: ;
      endcase
    endfunction

    function void note_pose(pose_item_t it);
      longint px, py, gy, rx, ry, tol_h, tol_x, tol_y, lim, ex, ey, s, c, vx, vy;
      longint sxs, sys, st, idx;
      bit [1:0] cause;
      drive_cmd_t cmd;
      px = it.pos_x; py = it.pos_y; gy = it.gyro;
      rx = sext32(tgt_xy[63:32]) - px;
      ry = sext32(tgt_xy[31:0]) - py;
      tol_h = longint'(tols[47:32]) << 8;
      tol_x = longint'(tols[31:16]) << 8;
      tol_y = longint'(tols[15:0]) << 8;
      lim = longint'(tols[63:48]);
      sxs = 0; sys = 0; st = 0; cause = CauseRun;
      if (it.action == ActStart) begin
        ex = clip32(rx); ey = clip32(ry);
        seed();
        hdg_err = clip32(tgt_hdg - gy);
        init_dsq = 64'(ex * ex) + 64'(ey * ey);
        last_dsq = init_dsq;
        active = 1;
        last_cause = CauseRun;
      end else if (!active) begin
        cause = last_cause;
      end else if (mag(sum_x) <= longint'(StallEps) && mag(sum_y) <= longint'(StallEps) &&
                   last_dsq <= (init_dsq >> 2) && mag(hdg_err) <= 3 * tol_h) begin
        cause = CauseStalled;
      end else begin
        idx = ((longint'(it.angle) * SineDepth) >> 16) % SineDepth;
        s = sine_q[idx];
        c = sine_q[(idx + SineDepth / 4) % SineDepth];
        ex = clip32((c * rx - s * ry) >>> 15);
        ey = clip32((c * ry + s * rx) >>> 15);
        last_dsq = 64'(ex * ex) + 64'(ey * ey);
        if (mag(ey) < tol_y && mag(ex) < tol_x && mag(hdg_err) < tol_h) begin
          cause = CauseReached;
        end else begin
          vx = pd_step(ex, kx, hist_x, sum_x);
          vy = pd_step(ey, ky, hist_y, sum_y);
          vx = shape(vx, longint'(lims[63:48]), longint'(lims[31:16]));
          vy = shape(vy, longint'(lims[47:32]), longint'(lims[15:0]));
          last_x = slew(vx, last_x, lim);
          last_y = slew(vy, last_y, lim);
          sxs = last_x; sys = last_y;
          if (turn_cfg[16]) begin
            hdg_err = clip32(tgt_hdg - gy);
            st = shape((hdg_err * kt) >>> 17, MaxMag, longint'(turn_cfg[15:0]));
            st = clip(st, -32768, 32767);
          end
        end
      end
      if (cause != CauseRun && active) begin
        active = 0;
        last_cause = cause;
      end
      cmd.sx = sxs[15:0]; cmd.sy = sys[15:0]; cmd.st = st[15:0]; cmd.cause = cause;
      expected_cmds.push_back(cmd);
    endfunction

    function void check_cmd(drive_cmd_t got);
      drive_cmd_t want;
      if (expected_cmds.size() == 0) begin
        $error("unexpected drive command transfer");
        errors++;
        return;
      end
      want = expected_cmds.pop_front();
      if (got.sx !== want.sx) begin
        $error("speed_x expected %0d got %0d", want.sx, got.sx); errors++;
      end
      if (got.sy !== want.sy) begin
        $error("speed_y expected %0d got %0d", want.sy, got.sy); errors++;
      end
      if (got.st !== want.st) begin
        $error("speed_turn expected %0d got %0d", want.st, got.st); errors++;
      end
      if (got.cause !== want.cause) begin
        $error("finish_cause expected %0d got %0d", want.cause, got.cause); errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  dtp_in_if  pose_bus ();
  dtp_out_if cmd_bus ();

  drive_to_point_pd_controller_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (pose_bus),
    .out_ch     (cmd_bus)
  );

  drive_cmd_board board;
  bit   steady;
  int   long_hold;
  int   poses_sent;
  int   idle_cycles;
  bit [63:0] regs[8];

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // stall watchdog: no transfer on either side for too long
  always @(posedge clk_i) begin
    if ((pose_bus.valid && pose_bus.ready) || (cmd_bus.valid && cmd_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // command receiver with random and long hold-offs
  initial begin
    int stall_left;
    drive_cmd_t got;
    stall_left = 0;
    cmd_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (cmd_bus.valid && cmd_bus.ready) begin
        got.sx = cmd_bus.speed_x; got.sy = cmd_bus.speed_y;
        got.st = cmd_bus.speed_turn; got.cause = cmd_bus.finish_cause;
        board.check_cmd(got);
      end
      if (long_hold > 0) begin
        long_hold--;
        cmd_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        cmd_bus.ready <= 1'b0;
      end else begin
        cmd_bus.ready <= 1'b1;
        if (!steady && $urandom_range(0, 7) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                                                   : $urandom_range(1, 3);
      end
    end
  end

  // write all eight registers, block idle
  task automatic load_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= regs[i];
      @(posedge clk_i);
      board.write_reg(3'(i), regs[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pose(logic act, logic signed [31:0] px, logic signed [31:0] py,
                           logic [15:0] ang, logic signed [31:0] gy);
    pose_item_t it;
    int gap;
    it.action = act; it.pos_x = px; it.pos_y = py; it.angle = ang; it.gyro = gy;
    pose_bus.valid        <= 1'b1;
    pose_bus.action       <= act;
    pose_bus.pos_x        <= px;
    pose_bus.pos_y        <= py;
    pose_bus.track_angle  <= ang;
    pose_bus.gyro_heading <= gy;
    do @(posedge clk_i); while (!pose_bus.ready);
    board.note_pose(it);
    poses_sent++;
    gap = 0;
    if (!steady && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 800) : $urandom_range(1, 5);
    if (gap > 0) begin
      pose_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    pose_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_cmds.size() != 0) @(posedge clk_i);
  endtask

  // approach, then park at a small fixed residual so a stall can build up
  task automatic run_move(int tx, int ty, int th);
    int ox, oy, rx, ry, n, park;
    logic [15:0] ang;
    ox = $urandom_range(0, 100 << 16) - (50 << 16);
    oy = $urandom_range(0, 100 << 16) - (50 << 16);
    rx = $urandom_range(0, 4 << 16) - (2 << 16);
    ry = $urandom_range(0, 4 << 16) - (2 << 16);
    n = $urandom_range(3, 14);
    park = $urandom_range(0, 6);
    ang = $urandom;
    send_pose(ActStart, tx + ox, ty + oy, ang, th + $urandom_range(0, 1 << 17) - (1 << 16));
    for (int k = 1; k <= n; k++) begin
      ang = ang + 16'($urandom_range(0, 512)) - 16'd256;
      send_pose(ActSample, tx + int'(longint'(ox) * (n - k) / n),
                ty + int'(longint'(oy) * (n - k) / n), ang,
                th + $urandom_range(0, 1 << 18) - (1 << 17));
    end
    for (int k = 0; k < park; k++)
      send_pose(ActSample, tx + rx, ty + ry, ang, th);
  endtask

  // stimulus
  initial begin
    int tx, ty, th, phase;
    board = new();
    steady = 1'b0;
    long_hold = 0;
    poses_sent = 0;
    idle_cycles = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CfgTargetXy;
    cfg_data_i <= '0;
    pose_bus.valid <= 1'b0;
    pose_bus.action <= ActStart;
    pose_bus.pos_x <= '0;
    pose_bus.pos_y <= '0;
    pose_bus.track_angle <= '0;
    pose_bus.gyro_heading <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sample before any move
    send_pose(ActSample, 32'sd0, 32'sd0, 16'd0, 32'sd0);
    wait_drain();

    // all registers at extreme values
    regs = '{64'h7FFF_FFFF_8000_0000, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF,
             64'h7FFF_FFFF, '1, 64'h1_FFFF, '1};
    load_regs();
    send_pose(ActStart, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 32'sh8000_0000);
    send_pose(ActSample, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'h0000, 32'sh8000_0000);
    send_pose(ActSample, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 32'sh7FFF_FFFF);
    send_pose(ActSample, 32'sd0, 32'sd0, 16'h4000, 32'sd0);
    send_pose(ActSample, 32'sh8000_0000, 32'sh8000_0000, 16'h8000, 32'sh8000_0000);
    wait_drain();

    // negative gains, zero limits and tolerances, turn off
    regs = '{64'h8000_0000_7FFF_FFFF, 64'h8000_0000, 64'h8000_0000, 64'h8000_0000,
             64'h8000_0000, '0, 64'h0, '0};
    load_regs();
    send_pose(ActStart, 32'sd0, 32'sd0, 16'h0, 32'sh7FFF_FFFF);
    send_pose(ActSample, 32'sd65536, 32'sh8000_0000, 16'hC000, 32'sh7FFF_FFFF);
    send_pose(ActSample, 32'sd0, 32'sd0, 16'h2000, 32'sd0);
    wait_drain();

    // default tolerances: reach the target, then an idle sample, then a stall
    regs = '{64'h0, 64'h0, 64'h0001_0000, 64'h0001_0000, 64'h0001_0000,
             64'h6000_6000_1000_1000, 64'h1_0800, TolReset};
    load_regs();
    send_pose(ActStart, 32'sd327680, 32'sd0, 16'h0, 32'sd0);
    send_pose(ActSample, 32'sd0, 32'sd0, 16'h1234, 32'sd0);
    send_pose(ActSample, 32'sd0, 32'sd0, 16'h0, 32'sd0);
    send_pose(ActStart, 32'sd655360, 32'sd0, 16'h0, 32'sd0);
    repeat (5) send_pose(ActSample, 32'sd65536, 32'sd0, 16'h0, 32'sd0);
    send_pose(ActSample, 32'sd0, 32'sd0, 16'h0, 32'sd0);
    wait_drain();

    // random phases
    phase = 0;
    while (poses_sent < 520) begin
      wait_drain();
      steady = (phase % 3 == 2);
      tx = $urandom_range(0, 200 << 16) - (100 << 16);
      ty = $urandom_range(0, 200 << 16) - (100 << 16);
      th = $urandom_range(0, 360 << 16) - (180 << 16);
      regs[CfgTargetXy]   = {32'(tx), 32'(ty)};
      regs[CfgTargetHdg]  = 64'(th);
      regs[CfgGainX]      = 64'(int'($urandom_range(0, 1 << 18)) - (1 << 16));
      regs[CfgGainY]      = 64'(int'($urandom_range(0, 1 << 18)) - (1 << 16));
      regs[CfgGainTurn]   = 64'(int'($urandom_range(0, 1 << 16)) - (1 << 14));
      regs[CfgSpeedLim]   = {16'($urandom), 16'($urandom), 16'($urandom_range(0, 4000)),
                             16'($urandom_range(0, 4000))};
      regs[CfgTurnSet]    = 64'($urandom_range(0, 131071));
      regs[CfgTolerances] = {16'($urandom), 16'($urandom_range(0, 16'h0800)),
                             16'($urandom_range(0, 16'h0400)),
                             16'($urandom_range(0, 16'h0400))};
      if (phase % 5 == 4) begin
        regs[CfgGainX] = {$urandom, $urandom};
        regs[CfgGainY] = {$urandom, $urandom};
        regs[CfgGainTurn] = {$urandom, $urandom};
        regs[CfgSpeedLim] = {$urandom, $urandom};
        regs[CfgTolerances] = {$urandom, $urandom};
      end
      load_regs();
      // receiver holds off while moves keep coming
      if (phase == 1) long_hold = 3000;
      for (int k = 0; k < 6; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          run_move(tx, ty, th);
        end else begin
          repeat ($urandom_range(1, 4))
            send_pose(1'($urandom), $urandom, $urandom, 16'($urandom), $urandom);
        end
      end
      phase++;
    end

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.expected_cmds.size() != 0) begin
      $error("drive commands still outstanding: %0d", board.expected_cmds.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
sv/dtp_pkg.sv
sv/dtp_if.sv
sv/dtp_serial_mult.sv
sv/dtp_sine_rom.sv
sv/drive_to_point_pd_controller_core.sv
sim/drive_to_point_pd_controller_core_tb.sv
